### hw/rtl/hsli_pkg.sv
package hsli_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned CntW      = 9;
  localparam int unsigned StepW     = 9;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ValW      = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatW     = 2;

  localparam logic [OpW-1:0] OpLoad  = 2'd0;
  localparam logic [OpW-1:0] OpQuery = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;
  localparam logic [StatW-1:0] StatBelow = 2'd3;

endpackage

### hw/rtl/hsli_if.sv
interface hsli_in_if;
  logic                              valid;
  logic                              ready;
  logic [hsli_pkg::OpW-1:0]          operation;
  logic [hsli_pkg::TimeW-1:0]        point_time;
  logic signed [hsli_pkg::ValW-1:0]  point_value;
  logic [hsli_pkg::TimeW-1:0]        query_time;

  modport source (output valid, operation, point_time, point_value, query_time, input ready);
  modport sink   (input valid, operation, point_time, point_value, query_time, output ready);
endinterface

interface hsli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hsli_pkg::ValW-1:0]  value;
  logic [hsli_pkg::IdxW-1:0]         segment_index;
  logic [hsli_pkg::StatW-1:0]        status;
  logic [hsli_pkg::CntW-1:0]         point_count;

  modport source (output valid, value, segment_index, status, point_count, input ready);
  modport sink   (input valid, value, segment_index, status, point_count, output ready);
endinterface

### hw/rtl/hsli_ram.sv
module hsli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/hsli_div.sv
module hsli_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hsli_pkg::TimeW-1:0]  off_i,
  input  logic [hsli_pkg::TimeW-1:0]  span_i,
  output logic                        done_o,
  output logic [hsli_pkg::FracBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(hsli_pkg::FracBits + 1);

  logic                          busy_q, busy_d;
  logic [CntBits-1:0]            cnt_q, cnt_d;
  logic [hsli_pkg::TimeW-1:0]    rem_q, rem_d;
  logic [hsli_pkg::TimeW-1:0]    span_q, span_d;
  logic [hsli_pkg::FracBits-1:0] quot_q, quot_d;
  logic [hsli_pkg::TimeW:0]      rem2;
  logic                          done_q, done_d;

  // One quotient bit per cycle, restoring; remainder stays below span.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    span_d = span_q;
    quot_d = quot_q;
    done_d = 1'b0;
    rem2   = {rem_q, 1'b0};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(hsli_pkg::FracBits);
      rem_d  = off_i;
      span_d = span_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, span_q}) begin
        rem_d  = hsli_pkg::TimeW'(rem2 - {1'b0, span_q});
        quot_d = {quot_q[hsli_pkg::FracBits-2:0], 1'b1};
      end else begin
        rem_d  = rem2[hsli_pkg::TimeW-1:0];
        quot_d = {quot_q[hsli_pkg::FracBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hw/rtl/hunt_search_linear_interpolator.sv
// Piecewise-linear interpolator over a table of ascending breakpoints.
// Input channel in_i: one transfer per item (load, query, clear, spare). Output
// channel out_o: exactly one transfer per item, in item order.
// A load appends a breakpoint to two 256-entry synchronous RAMs (time and
// value); the first kept point also fills entry 0 at time zero.
// A query hunts outward from the last found segment with a doubling step,
// bisects, reads both segment ends, divides serially for a 16-bit fraction and
// multiplies once.
// A load, clear or spare goes straight to the done state; the first load
// into an empty table passes through a second write state for entry 1 first. A
// query probes the time RAM once per search step (the start probe, the
// hunt probes and the bisection probes), then reads both segment ends,
// divides and forms the product; a query at time zero or on the last
// breakpoint skips the search, a query above the table or on an empty
// table goes straight to the done state, and one that lands on an upper
// breakpoint skips the division. One item is worked on at a time; the next
// is taken the cycle after the result moves into the output register.
// Reset clears the point count and the last found index; the RAMs need no
// clearing since only written entries are ever read.
// When the receiver stalls, the result waits in the output register; the
// block still takes the next item and finishes its work, then holds it
// until the output register frees up.
module hunt_search_linear_interpolator (
  input logic        clk_i,
  input logic        rst_ni,
  hsli_in_if.sink    in_i,
  hsli_out_if.source out_o
);

  localparam int unsigned IdxW  = hsli_pkg::IdxW;
  localparam int unsigned CntW  = hsli_pkg::CntW;
  localparam int unsigned StepW = hsli_pkg::StepW;
  localparam int unsigned TW    = hsli_pkg::TimeW;
  localparam int unsigned VW    = hsli_pkg::ValW;
  localparam int unsigned FB    = hsli_pkg::FracBits;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLoad2 = 4'd1;
  localparam logic [3:0] SProbe = 4'd2;
  localparam logic [3:0] SHup   = 4'd3;
  localparam logic [3:0] SHdn   = 4'd4;
  localparam logic [3:0] SBis   = 4'd5;
  localparam logic [3:0] SRdLo  = 4'd6;
  localparam logic [3:0] SRdHi  = 4'd7;
  localparam logic [3:0] SPrep  = 4'd8;
  localparam logic [3:0] SDivW  = 4'd9;
  localparam logic [3:0] SMul   = 4'd10;
  localparam logic [3:0] SFin   = 4'd11;
  localparam logic [3:0] SDone  = 4'd12;

  logic [3:0] state_q, state_d;

  // control state
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  lfi_q, lfi_d;
  logic             out_valid_q, out_valid_d;

  // working registers
  logic [TW-1:0]    last_time_q, last_time_d;
  logic [VW-1:0]    last_value_q, last_value_d;
  logic [TW-1:0]    qt_q, qt_d;
  logic [TW-1:0]    pt_q, pt_d;
  logic [VW-1:0]    pv_q, pv_d;
  logic [IdxW-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [StepW-1:0] step_q, step_d;
  logic [TW-1:0]    tlo_q, tlo_d, thi_q, thi_d;
  logic [VW-1:0]    vlo_q, vlo_d, vhi_q, vhi_d;
  logic [VW:0]      mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [VW+FB:0]   prod_q, prod_d;
  logic [VW-1:0]    res_value_q, res_value_d;
  logic [IdxW-1:0]  res_seg_q, res_seg_d;
  logic [hsli_pkg::StatW-1:0] res_stat_q, res_stat_d;
  logic [VW-1:0]    o_value_q, o_value_d;
  logic [IdxW-1:0]  o_seg_q, o_seg_d;
  logic [hsli_pkg::StatW-1:0] o_stat_q, o_stat_d;
  logic [CntW-1:0]  o_count_q, o_count_d;

  // memory ports
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [TW-1:0]    wtime, t_rd;
  logic [VW-1:0]    wval, v_rd;

  // divider
  logic             div_start, div_done;
  logic [TW-1:0]    div_off, div_span;
  logic [FB-1:0]    div_quot;

  // search helpers
  logic [IdxW-1:0]  end_idx, h_idx, lo_n, hi_n;
  logic [StepW-1:0] step_n;
  logic             search_end;
  logic [IdxW:0]    mid_sum;
  logic [VW:0]      diff;
  logic [VW+1:0]    fin_sum;

  assign end_idx = IdxW'(count_q - 1'b1);

  hsli_ram #(.Width(TW), .Depth(hsli_pkg::MaxPoints)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wtime),
    .raddr_i (raddr),
    .rdata_o (t_rd)
  );

  hsli_ram #(.Width(VW), .Depth(hsli_pkg::MaxPoints)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wval),
    .raddr_i (raddr),
    .rdata_o (v_rd)
  );

  hsli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .off_i   (div_off),
    .span_i  (div_span),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign div_off  = qt_q - tlo_q;
  assign div_span = thi_q - tlo_q;

  assign in_i.ready = (state_q == SIdle);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lfi_d        = lfi_q;
    last_time_d  = last_time_q;
    last_value_d = last_value_q;
    qt_d         = qt_q;
    pt_d         = pt_q;
    pv_d         = pv_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    step_d       = step_q;
    tlo_d        = tlo_q;
    thi_d        = thi_q;
    vlo_d        = vlo_q;
    vhi_d        = vhi_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    res_value_d  = res_value_q;
    res_seg_d    = res_seg_q;
    res_stat_d   = res_stat_q;
    o_value_d    = o_value_q;
    o_seg_d      = o_seg_q;
    o_stat_d     = o_stat_q;
    o_count_d    = o_count_q;
    out_valid_d  = out_valid_q;
    we           = 1'b0;
    waddr        = '0;
    wtime        = '0;
    wval         = '0;
    raddr        = lo_q;
    div_start    = 1'b0;
    lo_n         = lo_q;
    hi_n         = hi_q;
    step_n       = step_q;
    search_end   = 1'b0;
    h_idx        = (lfi_q >= end_idx) ? '0 : lfi_q;
    diff         = '0;
    fin_sum      = '0;

    // drop the output once the receiver takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          res_value_d = '0;
          res_seg_d   = '0;
          res_stat_d  = hsli_pkg::StatOk;
          qt_d        = in_i.query_time;
          state_d     = SDone;
          case (in_i.operation)
            hsli_pkg::OpLoad: begin
              if (in_i.point_time != '0) begin
                if (count_q == '0) begin
                  // entry 0 now at time zero, entry 1 next cycle
                  we           = 1'b1;
                  waddr        = '0;
                  wtime        = '0;
                  wval         = in_i.point_value;
                  pt_d         = in_i.point_time;
                  pv_d         = in_i.point_value;
                  count_d      = CntW'(2);
                  last_time_d  = in_i.point_time;
                  last_value_d = in_i.point_value;
                  state_d      = SLoad2;
                end else if (count_q[CntW-1]) begin
                  res_stat_d = hsli_pkg::StatFull;
                end else if (in_i.point_time <= last_time_q) begin
                  res_stat_d = hsli_pkg::StatBelow;
                end else begin
                  we           = 1'b1;
                  waddr        = count_q[IdxW-1:0];
                  wtime        = in_i.point_time;
                  wval         = in_i.point_value;
                  count_d      = count_q + 1'b1;
                  last_time_d  = in_i.point_time;
                  last_value_d = in_i.point_value;
                end
              end
            end
            hsli_pkg::OpQuery: begin
              if (count_q < CntW'(2)) begin
                res_stat_d = hsli_pkg::StatEmpty;
              end else if (in_i.query_time > last_time_q) begin
                res_value_d = last_value_q;
                res_seg_d   = end_idx;
              end else if (in_i.query_time == '0) begin
                lo_d    = '0;
                raddr   = '0;
                state_d = SRdLo;
              end else if (in_i.query_time == last_time_q) begin
                lo_d    = IdxW'(count_q - CntW'(2));
                raddr   = IdxW'(count_q - CntW'(2));
                state_d = SRdLo;
              end else begin
                hi_d    = h_idx;
                raddr   = h_idx;
                step_d  = StepW'(1);
                state_d = SProbe;
              end
            end
            hsli_pkg::OpClear: begin
              count_d = '0;
              lfi_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      SLoad2: begin
        we      = 1'b1;
        waddr   = IdxW'(1);
        wtime   = pt_q;
        wval    = pv_q;
        state_d = SDone;
      end

      SProbe: begin
        // hi_q holds the start index; pick the hunt direction
        if (t_rd < qt_q) begin
          lo_d    = hi_q;
          hi_d    = hi_q + 1'b1;
          raddr   = hi_q + 1'b1;
          state_d = SHup;
        end else begin
          lo_d    = hi_q - 1'b1;
          raddr   = hi_q - 1'b1;
          state_d = SHdn;
        end
      end

      SHup: begin
        if (t_rd < qt_q) begin
          lo_n   = hi_q;
          step_n = (step_q < StepW'(hsli_pkg::MaxPoints)) ? {step_q[StepW-2:0], 1'b0}
                                                           : step_q;
          hi_n   = (StepW'(end_idx - hi_q) > step_n) ? hi_q + step_n[IdxW-1:0] : end_idx;
          lo_d   = lo_n;
          hi_d   = hi_n;
          step_d = step_n;
          raddr  = hi_n;
        end else begin
          search_end = 1'b1;
        end
      end

      SHdn: begin
        if (t_rd > qt_q) begin
          hi_n   = lo_q;
          step_n = (step_q < StepW'(hsli_pkg::MaxPoints)) ? {step_q[StepW-2:0], 1'b0}
                                                           : step_q;
          lo_n   = ({1'b0, lo_q} > step_n) ? lo_q - step_n[IdxW-1:0] : '0;
          lo_d   = lo_n;
          hi_d   = hi_n;
          step_d = step_n;
          raddr  = lo_n;
        end else begin
          search_end = 1'b1;
        end
      end

      SBis: begin
        if (t_rd > qt_q) begin
          hi_n = mid_q;
        end else begin
          lo_n = mid_q;
        end
        search_end = 1'b1;
      end

      SRdLo: begin
        tlo_d     = t_rd;
        vlo_d     = v_rd;
        res_seg_d = lo_q;
        raddr     = lo_q + 1'b1;
        state_d   = SRdHi;
      end

      SRdHi: begin
        thi_d   = t_rd;
        vhi_d   = v_rd;
        state_d = SPrep;
      end

      SPrep: begin
        diff  = {vhi_q[VW-1], vhi_q} - {vlo_q[VW-1], vlo_q};
        neg_d = diff[VW];
        mag_d = diff[VW] ? (VW+1)'(-diff) : diff;
        if (div_off == div_span) begin
          // fraction is exactly one
          res_value_d = vhi_q;
          state_d     = SDone;
        end else begin
          div_start = 1'b1;
          state_d   = SDivW;
        end
      end

      SDivW: begin
        if (div_done) begin
          state_d = SMul;
        end
      end

      SMul: begin
        prod_d  = mag_q * {{(VW+1-FB){1'b0}}, div_quot};
        state_d = SFin;
      end

      SFin: begin
        if (neg_q) begin
          fin_sum = {{2{vlo_q[VW-1]}}, vlo_q} - {1'b0, prod_q[VW+FB:FB]};
        end else begin
          fin_sum = {{2{vlo_q[VW-1]}}, vlo_q} + {1'b0, prod_q[VW+FB:FB]};
        end
        res_value_d = fin_sum[VW-1:0];
        state_d     = SDone;
      end

      SDone: begin
        // hold until the output register is free or being freed
        if (!out_valid_q || out_o.ready) begin
          o_value_d   = res_value_q;
          o_seg_d     = res_seg_q;
          o_stat_d    = res_stat_q;
          o_count_d   = count_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase

    // close one search step: bisect further or read the segment
    if (search_end) begin
      mid_sum = {1'b0, hi_n} + {1'b0, lo_n};
      lo_d    = lo_n;
      hi_d    = hi_n;
      if ((hi_n - lo_n) > IdxW'(1)) begin
        mid_d   = mid_sum[IdxW:1];
        raddr   = mid_sum[IdxW:1];
        state_d = SBis;
      end else begin
        lfi_d   = lo_n;
        raddr   = lo_n;
        state_d = SRdLo;
      end
    end else begin
      mid_sum = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      lfi_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lfi_q       <= lfi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_time_q  <= last_time_d;
    last_value_q <= last_value_d;
    qt_q         <= qt_d;
    pt_q         <= pt_d;
    pv_q         <= pv_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    step_q       <= step_d;
    tlo_q        <= tlo_d;
    thi_q        <= thi_d;
    vlo_q        <= vlo_d;
    vhi_q        <= vhi_d;
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    res_value_q  <= res_value_d;
    res_seg_q    <= res_seg_d;
    res_stat_q   <= res_stat_d;
    o_value_q    <= o_value_d;
    o_seg_q      <= o_seg_d;
    o_stat_q     <= o_stat_d;
    o_count_q    <= o_count_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.value         = o_value_q;
  assign out_o.segment_index = o_seg_q;
  assign out_o.status        = o_stat_q;
  assign out_o.point_count   = o_count_q;

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One table operation as it goes into the block.
  typedef struct packed {
    logic [hsli_pkg::OpW-1:0]         op;
    logic [hsli_pkg::TimeW-1:0]       pt;
    logic signed [hsli_pkg::ValW-1:0] pv;
    logic [hsli_pkg::TimeW-1:0]       qt;
  } table_op_t;

  // One interpolation result as it comes out.
  typedef struct packed {
    logic signed [hsli_pkg::ValW-1:0] value;
    logic [hsli_pkg::IdxW-1:0]        seg;
    logic [hsli_pkg::StatW-1:0]       status;
    logic [hsli_pkg::CntW-1:0]        count;
  } interp_res_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsli_in_if  in_ch ();
  hsli_out_if out_ch ();

  hunt_search_linear_interpolator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the breakpoint table kept by the predictor.
  logic [hsli_pkg::TimeW-1:0] bp_time [hsli_pkg::MaxPoints];
  logic [hsli_pkg::ValW-1:0]  bp_value [hsli_pkg::MaxPoints];
  int unsigned      bp_count;
  int unsigned      hunt_start;

  table_op_t   pending_ops[$];
  interp_res_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          in_fired = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: %0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_op(input table_op_t t);
    pending_ops.insert(pending_ops.size(), t);
  endtask

  // Hunt outward from the last segment with a doubling step, then bisect.
  function automatic int unsigned locate_segment(input logic [hsli_pkg::TimeW-1:0] q);
    int unsigned last_idx, h, lo, hi, step, mid;
    last_idx = bp_count - 1;
    h = hunt_start;
    step = 1;
    if (h >= last_idx) h = 0;
    if (bp_time[h] < q) begin
      lo = h;
      hi = lo + 1;
      while (bp_time[hi] < q) begin
        lo = hi;
        if (step < hsli_pkg::MaxPoints) step = step << 1;
        hi = (last_idx - lo > step) ? lo + step : last_idx;
      end
    end else begin
      hi = h;
      lo = hi - 1;
      while (bp_time[lo] > q) begin
        hi = lo;
        if (step < hsli_pkg::MaxPoints) step = step << 1;
        lo = (hi > step) ? hi - step : 0;
      end
    end
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      if (bp_time[mid] > q) hi = mid;
      else lo = mid;
    end
    hunt_start = lo;
    return lo;
  endfunction

  // Truncating fraction, then truncated product of the value step.
  function automatic logic [hsli_pkg::ValW-1:0] blend(input logic [hsli_pkg::TimeW-1:0] q,
                                                      input int unsigned lo);
    logic [63:0] span, off, frac, mag, part;
    longint signed v_lo, v_hi, d;
    span = 64'(bp_time[lo+1]) - 64'(bp_time[lo]);
    off = 64'(q - bp_time[lo]);
    frac = (off << hsli_pkg::FracBits) / span;
    v_lo = longint'(signed'(bp_value[lo]));
    v_hi = longint'(signed'(bp_value[lo+1]));
    d = v_hi - v_lo;
    if (frac >= (64'd1 << hsli_pkg::FracBits)) return bp_value[lo+1];
    mag = (d < 0) ? 64'(-d) : 64'(d);
    part = (mag * frac) >> hsli_pkg::FracBits;
    if (d < 0) return hsli_pkg::ValW'(v_lo - longint'(part));
    return hsli_pkg::ValW'(v_lo + longint'(part));
  endfunction

  function automatic interp_res_t predict_result(input table_op_t t);
    interp_res_t r;
    int unsigned lo;
    r = '0;
    r.status = hsli_pkg::StatOk;
    case (t.op)
      hsli_pkg::OpLoad: begin
        if (t.pt != 0) begin
          if (bp_count == 0) begin
            bp_time[0] = '0;
            bp_value[0] = t.pv;
            bp_time[1] = t.pt;
            bp_value[1] = t.pv;
            bp_count = 2;
          end else if (bp_count >= hsli_pkg::MaxPoints) begin
            r.status = hsli_pkg::StatFull;
          end else if (t.pt <= bp_time[bp_count-1]) begin
            r.status = hsli_pkg::StatBelow;
          end else begin
            bp_time[bp_count] = t.pt;
            bp_value[bp_count] = t.pv;
            bp_count++;
          end
        end
      end
      hsli_pkg::OpQuery: begin
        if (bp_count < 2) begin
          r.status = hsli_pkg::StatEmpty;
        end else if (t.qt > bp_time[bp_count-1]) begin
          r.value = bp_value[bp_count-1];
          r.seg = hsli_pkg::IdxW'(bp_count - 1);
        end else if (t.qt < bp_time[0]) begin
          r.status = hsli_pkg::StatBelow;
        end else begin
          if (t.qt == bp_time[0]) lo = 0;
          else if (t.qt == bp_time[bp_count-1]) lo = bp_count - 2;
          else lo = locate_segment(t.qt);
          r.value = blend(t.qt, lo);
          r.seg = hsli_pkg::IdxW'(lo);
        end
      end
      hsli_pkg::OpClear: begin
        bp_count = 0;
        hunt_start = 0;
      end
      default: ;
    endcase
    r.count = hsli_pkg::CntW'(bp_count);
    return r;
  endfunction

  // Mostly short gaps, sometimes long, sometimes none at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: present the next pending item at the falling edge, hold it
  // until the transfer, then wait a random gap.
  int unsigned send_gap = 0;
  bit          send_busy = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (send_busy && in_fired) begin
        // Transfer happened on the last rising edge; predict it now.
        send_busy = 1'b0;
        expected_results.insert(expected_results.size(),
                                predict_result(pending_ops.pop_front()));
        send_gap = pick_gap();
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          send_busy = 1'b1;
          in_ch.valid <= 1'b1;
          in_ch.operation <= pending_ops[0].op;
          in_ch.point_time <= pending_ops[0].pt;
          in_ch.point_value <= pending_ops[0].pv;
          in_ch.query_time <= pending_ops[0].qt;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls at random, with long stretches too.
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Monitor: note input transfers, compare each result transfer with the
  // oldest prediction.
  always @(posedge clk_i) begin
    in_fired = rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_ch.status), 64'd0);
        end else begin
          interp_res_t e;
          e = expected_results.pop_front();
          if (out_ch.value !== e.value) report_mismatch("value", 64'(out_ch.value), 64'(e.value));
          if (out_ch.segment_index !== e.seg)
            report_mismatch("segment_index", 64'(out_ch.segment_index), 64'(e.seg));
          if (out_ch.status !== e.status)
            report_mismatch("status", 64'(out_ch.status), 64'(e.status));
          if (out_ch.point_count !== e.count)
            report_mismatch("point_count", 64'(out_ch.point_count), 64'(e.count));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic table_op_t make_op(input logic [hsli_pkg::OpW-1:0] op,
                                        input logic [hsli_pkg::TimeW-1:0] pt,
                                        input logic [hsli_pkg::ValW-1:0] pv,
                                        input logic [hsli_pkg::TimeW-1:0] qt);
    table_op_t t;
    t.op = op;
    t.pt = pt;
    t.pv = pv;
    t.qt = qt;
    return t;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // Clear, build an ascending table of random points, then query it.
  task automatic queue_random_table(input int unsigned points, input int unsigned queries);
    logic [hsli_pkg::TimeW-1:0] t_now;
    logic [hsli_pkg::TimeW-1:0] t_max;
    int unsigned stride;
    stride = ($urandom_range(0, 3) == 0) ? 32'h00ff_ffff : $urandom_range(2, 5000);
    t_now = $urandom_range(1, 100);
    queue_op(make_op(hsli_pkg::OpClear, rand32(), rand32(), rand32()));
    for (int unsigned i = 0; i < points; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_op(make_op(hsli_pkg::OpLoad, t_now - $urandom_range(0, 3), rand32(), rand32()));
      queue_op(make_op(hsli_pkg::OpLoad, t_now, rand32(), rand32()));
      t_max = t_now;
      t_now = t_now + $urandom_range(1, stride);
    end
    for (int unsigned i = 0; i < queries; i++) begin
      case ($urandom_range(0, 9))
        0: queue_op(make_op(hsli_pkg::OpQuery, rand32(), rand32(), rand32()));
        1: queue_op(make_op(hsli_pkg::OpQuery, rand32(), rand32(), t_max));
        2: queue_op(make_op(hsli_pkg::OpW'($urandom_range(0, 3)), rand32(), rand32(),
                            rand32()));
        default: queue_op(make_op(hsli_pkg::OpQuery, rand32(), rand32(),
                                  $urandom_range(0, t_max)));
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = hsli_pkg::OpLoad;
    in_ch.point_time = '0;
    in_ch.point_value = '0;
    in_ch.query_time = '0;
    out_ch.ready = 1'b0;
    bp_count = 0;
    hunt_start = 0;

    // Directed: empty table, dropped zero time, extremes, exact breakpoints,
    // out-of-order load, the spare operation code, clear.
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd5));
    queue_op(make_op(hsli_pkg::OpLoad, '0, 32'h7fff_ffff, '0));
    queue_op(make_op(hsli_pkg::OpLoad, 32'd100, 32'h8000_0000, '0));
    queue_op(make_op(hsli_pkg::OpLoad, 32'd100, 32'd1, '0));
    queue_op(make_op(hsli_pkg::OpLoad, 32'd300, 32'h7fff_ffff, '0));
    queue_op(make_op(hsli_pkg::OpLoad, 32'hffff_ffff, 32'h8000_0000, '0));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd0));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd100));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd299));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd300));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'd150));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'hffff_fffe));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'hffff_ffff));
    queue_op(make_op(hsli_pkg::OpLoad, 32'hffff_ffff, 32'd7, '0));
    queue_op(make_op(hsli_pkg::OpSpare, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    queue_op(make_op(hsli_pkg::OpClear, '0, '0, '0));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'hffff_ffff));

    // Fill the table to the top, hit the full case, query across it.
    queue_op(make_op(hsli_pkg::OpClear, '0, '0, '0));
    for (int unsigned i = 1; i < hsli_pkg::MaxPoints; i++)
      queue_op(make_op(hsli_pkg::OpLoad, i * 1000, rand32(), '0));
    queue_op(make_op(hsli_pkg::OpLoad, 32'hffff_ffff, rand32(), '0));
    for (int unsigned i = 0; i < 30; i++)
      queue_op(make_op(hsli_pkg::OpQuery, '0, '0, $urandom_range(0, 256000)));
    queue_op(make_op(hsli_pkg::OpQuery, '0, '0, 32'hffff_ffff));

    // Random tables, mostly small.
    for (int unsigned i = 0; i < 6; i++)
      queue_random_table($urandom_range(1, 12), $urandom_range(10, 25));
    queue_random_table(60, 25);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0 && expected_results.size() == 0);
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
